// ===== src/fir_filter_programmable_taps_top_assert.svh =====
// assertion macros shared by the fir filter rtl
`ifndef FIR_FILTER_PROGRAMMABLE_TAPS_TOP_ASSERT_SVH
`define FIR_FILTER_PROGRAMMABLE_TAPS_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define FIRPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define FIRPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/firpt_pkg.sv =====
// package: constants, payload types and control struct of the fir filter
package firpt_pkg;

    localparam int MAX_TAPS     = 256;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEFF_WIDTH  = 16;

    localparam int ADDR_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TAP_W    = $clog2(MAX_TAPS + 1);
    localparam int ACC_FULL = SAMPLE_WIDTH + COEFF_WIDTH + TAP_W;
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;

    localparam int TAP_COUNT_W  = 9;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 1;
    localparam int COEFF_IDX_W  = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PASSTHROUGH = 1'b1;

    // item actions
    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;

    typedef struct packed {
        logic                           action;
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic [COEFF_IDX_W-1:0]         coeff_index;
        logic signed [COEFF_WIDTH-1:0]  coeff_value;
    } fir_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered_out;
        logic signed [SAMPLE_WIDTH-1:0] passthrough_out;
    } fir_out_t;

    typedef struct packed {
        logic start;   // clear accumulator
        logic mul_en;  // memory read data valid, register product
        logic acc_en;  // product register valid, accumulate
    } mac_ctrl_t;

endpackage

// ===== src/firpt_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module firpt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/firpt_mac.sv =====
// shared multiply-accumulate unit with rounding and saturation to the sample format
module firpt_mac import firpt_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mac_ctrl_t                      ctrl,
    input  logic [SAMPLE_WIDTH-1:0]        sample_rd,
    input  logic [COEFF_WIDTH-1:0]         coeff_rd,
    output logic signed [SAMPLE_WIDTH-1:0] result
);

    localparam int PW = SAMPLE_WIDTH + COEFF_WIDTH;
    localparam int QW = ACC_W - COEFF_WIDTH + 1;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEFF_WIDTH - 2);

    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] rounded;
    logic signed [QW-1:0]    q;

    // add with saturation at the accumulator limits
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
            if (s[ACC_W] != s[ACC_W-1])
            begin
                sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end
            else
            begin
                sat_add = s[ACC_W-1:0];
            end
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= $signed(sample_rd) * $signed(coeff_rd);
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.start)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_next = sat_add(acc_reg, ACC_W'(prod_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // round half up, floor shift, clamp to the sample range
    always_comb
    begin
        rounded = sat_add(acc_reg, RND);
        q       = rounded[ACC_W-1:COEFF_WIDTH-1];
        if (q[QW-1:SAMPLE_WIDTH-1] == {(QW-SAMPLE_WIDTH+1){q[QW-1]}})
        begin
            result = q[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            result = q[QW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                             : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

endmodule

// ===== src/fir_filter_programmable_taps_top.sv =====
// top level: fir filter with programmable taps, coefficient and delay line rams
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_data   (fir_in_t)
//  out     | output    | out_valid/out_stall | out_data (fir_out_t)
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// a load item leaves in_stall low; a sample item keeps in_stall high through its tap walk
// (only the finish step with no taps): one tap per cycle through the shared mac, a drain of
// the read, product and accumulate steps, one finish step
// after reset a clearing pass writes zero to every address of both rams, in_stall high
// the next item is taken while the previous result still waits in the output register
// a finished result waits in the finish step while out_stall holds the previous one
module fir_filter_programmable_taps_top import firpt_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  fir_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output fir_out_t               out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    `include "fir_filter_programmable_taps_top_assert.svh"

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_RUN    = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [TAP_COUNT_W-1:0] tap_count_reg;
    logic                   pt_en_reg;

    // sequencer
    logic [TAP_W-1:0]  rd_cnt_reg, rd_cnt_next;     // tap counter, also clear counter
    logic [TAP_W-1:0]  taps_reg, taps_next;
    logic [TAP_W-1:0]  taps_eff;
    logic [ADDR_W-1:0] wp_reg, wp_next, wp_inc;     // newest sample position
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;   // delay line read position
    logic              s1_valid_reg, s1_valid_next; // ram read data valid
    logic              s2_valid_reg;                // product register valid

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic                           out_valid_reg, out_valid_next;
    fir_out_t                       out_data_reg;
    logic                           out_load;

    logic in_accept, out_accept, sample_accept, load_accept;

    // ram ports
    logic                    dl_we, cf_we, rd_en;
    logic [ADDR_W-1:0]       dl_waddr, cf_waddr;
    logic [SAMPLE_WIDTH-1:0] dl_wdata, dl_rdata;
    logic [COEFF_WIDTH-1:0]  cf_wdata, cf_rdata;

    mac_ctrl_t                      mac_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] mac_result;

    assign in_stall      = (state_reg != ST_IDLE);
    assign in_accept     = in_valid && !in_stall;
    assign sample_accept = in_accept && (in_data.action == ACT_FILTER);
    assign load_accept   = in_accept && (in_data.action == ACT_LOAD);
    assign out_accept    = out_valid_reg && !out_stall;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

    // tap count above the store depth uses the whole store
    always_comb
    begin
        if (32'(tap_count_reg) > 32'(MAX_TAPS))
        begin
            taps_eff = TAP_W'(MAX_TAPS);
        end
        else
        begin
            taps_eff = TAP_W'(tap_count_reg);
        end
    end

    assign wp_inc = (wp_reg == ADDR_W'(MAX_TAPS - 1)) ? '0 : wp_reg + ADDR_W'(1);

    // configuration writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= '0;
            pt_en_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TAP_COUNT:   tap_count_reg <= cfg_data[TAP_COUNT_W-1:0];
                CFG_PASSTHROUGH: pt_en_reg     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        rd_cnt_next   = rd_cnt_reg;
        taps_next     = taps_reg;
        wp_next       = wp_reg;
        rd_addr_next  = rd_addr_reg;
        s1_valid_next = 1'b0;
        rd_en         = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                rd_cnt_next = rd_cnt_reg + TAP_W'(1);
                if (rd_cnt_reg == TAP_W'(MAX_TAPS - 1))
                begin
                    rd_cnt_next = '0;
                    state_next  = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sample_accept)
                begin
                    wp_next      = wp_inc;
                    rd_addr_next = wp_inc;
                    rd_cnt_next  = '0;
                    taps_next    = taps_eff;
                    state_next   = (taps_eff == '0) ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                rd_en         = 1'b1;
                s1_valid_next = 1'b1;
                rd_cnt_next   = rd_cnt_reg + TAP_W'(1);
                rd_addr_next  = (rd_addr_reg == '0) ? ADDR_W'(MAX_TAPS - 1)
                                                    : rd_addr_reg - ADDR_W'(1);
                if (rd_cnt_reg == taps_reg - TAP_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last product to reach the accumulator
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            rd_cnt_reg   <= '0;
            taps_reg     <= '0;
            wp_reg       <= '0;
            rd_addr_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            taps_reg     <= taps_next;
            wp_reg       <= wp_next;
            rd_addr_reg  <= rd_addr_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // ram write ports: clearing pass, or the accepted item
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            dl_we    = 1'b1;
            dl_waddr = rd_cnt_reg[ADDR_W-1:0];
            dl_wdata = '0;
            cf_we    = 1'b1;
            cf_waddr = rd_cnt_reg[ADDR_W-1:0];
            cf_wdata = '0;
        end
        else
        begin
            dl_we    = sample_accept;
            dl_waddr = wp_inc;
            dl_wdata = in_data.sample_in;
            // index beyond the store is dropped
            cf_we    = load_accept && (32'(in_data.coeff_index) < 32'(MAX_TAPS));
            cf_waddr = ADDR_W'(in_data.coeff_index);
            cf_wdata = in_data.coeff_value;
        end
    end

    firpt_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_WIDTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .re    (rd_en),
        .raddr (rd_addr_reg),
        .rdata (dl_rdata)
    );

    firpt_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (COEFF_WIDTH)
    ) u_coeff_ram (
        .clk   (clk),
        .we    (cf_we),
        .waddr (cf_waddr),
        .wdata (cf_wdata),
        .re    (rd_en),
        .raddr (rd_cnt_reg[ADDR_W-1:0]),
        .rdata (cf_rdata)
    );

    assign mac_ctrl.start  = sample_accept;
    assign mac_ctrl.mul_en = s1_valid_reg;
    assign mac_ctrl.acc_en = s2_valid_reg;

    firpt_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .sample_rd (dl_rdata),
        .coeff_rd  (cf_rdata),
        .result    (mac_result)
    );

    // raw sample kept for the passthrough output
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            x_reg <= in_data.sample_in;
        end
    end

    // output register: filled in the finish step, emptied by a transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.filtered_out    <= mac_result;
            out_data_reg.passthrough_out <= pt_en_reg ? x_reg : '0;
        end
    end

    `FIRPT_ASSERT_NOW(a_prod_in_window, s2_valid_reg,
        (state_reg == ST_RUN) || (state_reg == ST_DRAIN),
        "product valid outside the tap walk")
    `FIRPT_ASSERT_NOW(a_finish_drained, state_reg == ST_FINISH,
        !s1_valid_reg && !s2_valid_reg,
        "result taken before the mac pipeline drained")
    `FIRPT_ASSERT_NOW(a_tap_bound, state_reg == ST_RUN,
        (rd_cnt_reg < taps_reg) && (taps_reg <= TAP_W'(MAX_TAPS)),
        "tap counter beyond the active taps")
    `FIRPT_ASSERT_NEXT(a_sample_busy, sample_accept,
        in_stall,
        "sample transfer did not start the tap walk")

endmodule
